/* design/vpa_pkg.sv */
// Shared types and constants of the variable partition allocator.
package vpa_pkg;

   localparam int ADDR_W    = 16;
   localparam int CSR_IDX_W = 2;

   localparam logic [ADDR_W-1:0] MEM_SIZE_RST = 16'd1024;
   localparam logic [ADDR_W-1:0] MIN_REM_RST  = 16'd10;
   localparam logic [ADDR_W-1:0] FIRST_ID     = 16'd1;

   localparam logic OP_ALLOC   = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NO_MEM    = 2'd1;
   localparam logic [1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [1:0] ST_REJECT    = 2'd3;

   localparam logic [1:0] POL_FIRST = 2'd0;
   localparam logic [1:0] POL_BEST  = 2'd1;
   localparam logic [1:0] POL_WORST = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_MEM_SIZE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_POLICY   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_REM  = 2'd2;

   typedef struct packed {
      logic [ADDR_W-1:0] start;
      logic [ADDR_W-1:0] length;
   } free_ent_type;

   typedef struct packed {
      logic [ADDR_W-1:0] id;
      logic [ADDR_W-1:0] start;
      logic [ADDR_W-1:0] length;
      logic [ADDR_W-1:0] age;
   } alloc_ent_type;

endpackage

/* design/vpa_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
module vpa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* design/variable_partition_allocator.sv */
// Top level of the variable partition allocator: sequencer around the two table RAMs.
//
// Manages memory_size units from address zero with a free-block table and an
// allocation table, each held in a RAM with a registered read; only
// the valid bits live in flip-flops. A beat is taken when start is high and busy
// is low; exactly one result comes back per beat as a one-cycle rsp_valid strobe
// that the receiver must take as it comes. Every pass reads one RAM entry per
// cycle, so time per beat follows from the depths of the free and allocation tables.
// A rejected allocate (zero size or full table) keeps busy low and strobes its
// result in the cycle after the accepting edge. An allocate keeps busy high
// through the free scan, grant, age update and write of the new entry. A
// release keeps busy high through the find, merge scan, merge write and age
// update; an unknown id ends after the find, and one with no free neighbour and
// no free table slot ends after the merge scan. An allocate that has to compact
// rescans the allocation table for each placement to find the next-newest entry,
// then scans the free table again. The result strobe falls in the first cycle
// with busy low again. After reset and after every memory_size write the block
// rebuilds the free table in S_INIT with busy high.
module variable_partition_allocator #(
   parameter int FREE_ENTRIES  = 16,
   parameter int ALLOC_ENTRIES = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic                            req_op,
   input  logic [vpa_pkg::ADDR_W-1:0]      req_request_size,
   input  logic [vpa_pkg::ADDR_W-1:0]      req_release_pid,
   output logic                            rsp_valid,
   output logic [1:0]                      rsp_status,
   output logic [vpa_pkg::ADDR_W-1:0]      rsp_owner_pid,
   output logic [vpa_pkg::ADDR_W-1:0]      rsp_block_start,
   output logic [vpa_pkg::ADDR_W-1:0]      rsp_block_size,
   output logic                            rsp_compacted,
   input  logic                            csr_we,
   input  logic [vpa_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [vpa_pkg::ADDR_W-1:0]      csr_wdata
);

   import vpa_pkg::*;

   localparam int FIW  = $clog2(FREE_ENTRIES);
   localparam int AIW  = $clog2(ALLOC_ENTRIES);
   localparam int MAXE = (FREE_ENTRIES > ALLOC_ENTRIES) ? FREE_ENTRIES : ALLOC_ENTRIES;
   localparam int SW   = $clog2(MAXE + 1);
   localparam int SUMW = ADDR_W + FIW + 1;
   localparam int CAW  = ADDR_W + AIW + 1;

   typedef enum logic [3:0] {
      S_INIT, S_IDLE,
      S_A_SCAN, S_A_GRANT, S_A_AGE, S_A_PUT,
      S_C_SCAN,
      S_R_FIND, S_R_MERGE, S_R_APPLY, S_R_AGE
   } state_type;

   // Sequencer state and scan pipeline
   state_type         state_ff, state_in;
   logic [SW-1:0]     idx_ff, idx_in;
   logic [SW-1:0]     pidx_ff, pidx_in;
   logic              pend_ff, pend_in;

   // Configuration and id counter
   logic [ADDR_W-1:0] mem_units_ff, mem_units_in;
   logic [1:0]        policy_ff, policy_in;
   logic [ADDR_W-1:0] min_rem_ff, min_rem_in;
   logic [ADDR_W-1:0] next_id_ff, next_id_in;

   // Valid bits of the tables and the compaction placement marks
   logic [FREE_ENTRIES-1:0]  free_vld_ff, free_vld_in;
   logic [ALLOC_ENTRIES-1:0] alloc_vld_ff, alloc_vld_in;
   logic [ALLOC_ENTRIES-1:0] placed_ff, placed_in;

   // Current beat
   logic [ADDR_W-1:0] size_ff, size_in;
   logic [ADDR_W-1:0] owner_ff, owner_in;
   logic [AIW-1:0]    slot_ff, slot_in;
   logic              comp_ff, comp_in;

   // Fit search
   logic              best_found_ff, best_found_in;
   logic [FIW-1:0]    best_idx_ff, best_idx_in;
   logic [ADDR_W-1:0] best_start_ff, best_start_in;
   logic [ADDR_W-1:0] best_len_ff, best_len_in;
   logic [SUMW-1:0]   sum_ff, sum_in;

   // Compaction
   logic              sel_found_ff, sel_found_in;
   logic [AIW-1:0]    sel_idx_ff, sel_idx_in;
   alloc_ent_type     sel_ent_ff, sel_ent_in;
   logic [CAW-1:0]    addr_ff, addr_in;

   // Release
   logic              a_found_ff, a_found_in;
   logic [AIW-1:0]    a_idx_ff, a_idx_in;
   alloc_ent_type     a_ent_ff, a_ent_in;
   logic              lo_found_ff, lo_found_in;
   logic [FIW-1:0]    lo_idx_ff, lo_idx_in;
   logic [ADDR_W-1:0] lo_start_ff, lo_start_in;
   logic [ADDR_W-1:0] lo_len_ff, lo_len_in;
   logic              hi_found_ff, hi_found_in;
   logic [FIW-1:0]    hi_idx_ff, hi_idx_in;
   logic [ADDR_W-1:0] hi_len_ff, hi_len_in;

   // Granted block
   logic [ADDR_W-1:0] bstart_ff, bstart_in;
   logic [ADDR_W-1:0] bsize_ff, bsize_in;

   // Result registers
   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;
   logic [ADDR_W-1:0] rsp_owner_ff, rsp_owner_in;
   logic [ADDR_W-1:0] rsp_start_ff, rsp_start_in;
   logic [ADDR_W-1:0] rsp_size_ff, rsp_size_in;
   logic              rsp_comp_ff, rsp_comp_in;

   // RAM ports
   logic              free_we;
   logic [FIW-1:0]    free_waddr;
   free_ent_type      free_wdata;
   free_ent_type      free_rdata;
   logic              alloc_we;
   logic [AIW-1:0]    alloc_waddr;
   alloc_ent_type     alloc_wdata;
   alloc_ent_type     alloc_rdata;

   // Lowest unused entries of each table
   logic              aslot_found;
   logic [AIW-1:0]    aslot;
   logic              fslot_found;
   logic [FIW-1:0]    fslot;

   logic              free_scan;
   logic [SW-1:0]     scan_lim;
   logic              issue;
   logic              scan_end;
   logic [FIW-1:0]    pf;
   logic [AIW-1:0]    pa;

   vpa_ram #(.WIDTH($bits(free_ent_type)), .DEPTH(FREE_ENTRIES)) u_free_ram (
      .clock (clock),
      .we    (free_we),
      .waddr (free_waddr),
      .wdata (free_wdata),
      .raddr (idx_ff[FIW-1:0]),
      .rdata (free_rdata)
   );

   vpa_ram #(.WIDTH($bits(alloc_ent_type)), .DEPTH(ALLOC_ENTRIES)) u_alloc_ram (
      .clock (clock),
      .we    (alloc_we),
      .waddr (alloc_waddr),
      .wdata (alloc_wdata),
      .raddr (idx_ff[AIW-1:0]),
      .rdata (alloc_rdata)
   );

   always_comb begin
      aslot_found = 1'b0;
      aslot       = '0;
      for (int i = ALLOC_ENTRIES - 1; i >= 0; i--) begin
         if (!alloc_vld_ff[i]) begin
            aslot_found = 1'b1;
            aslot       = AIW'(i);
         end
      end
   end

   always_comb begin
      fslot_found = 1'b0;
      fslot       = '0;
      for (int i = FREE_ENTRIES - 1; i >= 0; i--) begin
         if (!free_vld_ff[i]) begin
            fslot_found = 1'b1;
            fslot       = FIW'(i);
         end
      end
   end

   // Scan pipeline: issue one read a cycle, process the entry read the cycle before.
   assign free_scan = (state_ff == S_A_SCAN) || (state_ff == S_R_MERGE);
   assign scan_lim  = free_scan ? SW'(FREE_ENTRIES) : SW'(ALLOC_ENTRIES);
   assign issue     = idx_ff < scan_lim;
   assign scan_end  = !issue && !pend_ff;
   assign pf        = pidx_ff[FIW-1:0];
   assign pa        = pidx_ff[AIW-1:0];

   always_comb begin
      logic                better;
      logic [ADDR_W-1:0]   left;
      logic [ADDR_W:0]     blk_end;
      logic [ADDR_W:0]     rel_end;
      logic [CAW-1:0]      mem_ext;
      logic [CAW-1:0]      rest;

      state_in      = state_ff;
      idx_in        = idx_ff;
      pidx_in       = idx_ff;
      pend_in       = 1'b0;
      mem_units_in  = mem_units_ff;
      policy_in     = policy_ff;
      min_rem_in    = min_rem_ff;
      next_id_in    = next_id_ff;
      free_vld_in   = free_vld_ff;
      alloc_vld_in  = alloc_vld_ff;
      placed_in     = placed_ff;
      size_in       = size_ff;
      owner_in      = owner_ff;
      slot_in       = slot_ff;
      comp_in       = comp_ff;
      best_found_in = best_found_ff;
      best_idx_in   = best_idx_ff;
      best_start_in = best_start_ff;
      best_len_in   = best_len_ff;
      sum_in        = sum_ff;
      sel_found_in  = sel_found_ff;
      sel_idx_in    = sel_idx_ff;
      sel_ent_in    = sel_ent_ff;
      addr_in       = addr_ff;
      a_found_in    = a_found_ff;
      a_idx_in      = a_idx_ff;
      a_ent_in      = a_ent_ff;
      lo_found_in   = lo_found_ff;
      lo_idx_in     = lo_idx_ff;
      lo_start_in   = lo_start_ff;
      lo_len_in     = lo_len_ff;
      hi_found_in   = hi_found_ff;
      hi_idx_in     = hi_idx_ff;
      hi_len_in     = hi_len_ff;
      bstart_in     = bstart_ff;
      bsize_in      = bsize_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_owner_in  = rsp_owner_ff;
      rsp_start_in  = rsp_start_ff;
      rsp_size_in   = rsp_size_ff;
      rsp_comp_in   = rsp_comp_ff;
      free_we       = 1'b0;
      free_waddr    = '0;
      free_wdata    = '0;
      alloc_we      = 1'b0;
      alloc_waddr   = '0;
      alloc_wdata   = '0;
      better        = 1'b0;
      left          = free_rdata.length - size_ff;
      blk_end       = {1'b0, free_rdata.start} + {1'b0, free_rdata.length};
      rel_end       = {1'b0, a_ent_ff.start} + {1'b0, a_ent_ff.length};
      mem_ext       = CAW'(mem_units_ff);
      rest          = mem_ext - addr_ff;

      // Advance the read pointer in every scanning state.
      if ((state_ff == S_A_SCAN) || (state_ff == S_C_SCAN) || (state_ff == S_A_AGE) ||
          (state_ff == S_R_FIND) || (state_ff == S_R_MERGE) || (state_ff == S_R_AGE)) begin
         pend_in = issue;
         if (issue) begin
            idx_in = idx_ff + SW'(1);
         end
      end

      unique case (state_ff)
         S_INIT: begin
            // Rebuild the reset layout: one free block covering everything.
            free_we      = 1'b1;
            free_waddr   = '0;
            free_wdata   = '{start: '0, length: mem_units_ff};
            free_vld_in  = '0;
            free_vld_in[0] = (mem_units_ff != '0);
            alloc_vld_in = '0;
            state_in     = S_IDLE;
         end

         S_IDLE: begin
            idx_in = '0;
            if (start) begin
               size_in = req_request_size;
               comp_in = 1'b0;
               if (req_op == OP_ALLOC) begin
                  owner_in   = next_id_ff;
                  next_id_in = next_id_ff + ADDR_W'(1);
                  if ((req_request_size == '0) || !aslot_found) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_REJECT;
                     rsp_owner_in  = next_id_ff;
                     rsp_start_in  = '0;
                     rsp_size_in   = '0;
                     rsp_comp_in   = 1'b0;
                  end else begin
                     slot_in       = aslot;
                     best_found_in = 1'b0;
                     sum_in        = '0;
                     state_in      = S_A_SCAN;
                  end
               end else begin
                  owner_in   = req_release_pid;
                  a_found_in = 1'b0;
                  state_in   = S_R_FIND;
               end
            end
         end

         S_A_SCAN: begin
            if (pend_ff && free_vld_ff[pf]) begin
               sum_in = sum_ff + SUMW'(free_rdata.length);
               if (free_rdata.length >= size_ff) begin
                  case (policy_ff)
                     POL_BEST: better = (free_rdata.length < best_len_ff) ||
                        ((free_rdata.length == best_len_ff) &&
                         (free_rdata.start < best_start_ff));
                     POL_WORST: better = (free_rdata.length > best_len_ff) ||
                        ((free_rdata.length == best_len_ff) &&
                         (free_rdata.start < best_start_ff));
                     default: better = free_rdata.start < best_start_ff;
                  endcase
                  if (!best_found_ff || better) begin
                     best_found_in = 1'b1;
                     best_idx_in   = pf;
                     best_start_in = free_rdata.start;
                     best_len_in   = free_rdata.length;
                  end
               end
            end
            if (scan_end) begin
               idx_in = '0;
               if (best_found_ff) begin
                  state_in = S_A_GRANT;
               end else if (!comp_ff && (sum_ff >= SUMW'(size_ff))) begin
                  placed_in    = '0;
                  addr_in      = '0;
                  sel_found_in = 1'b0;
                  state_in     = S_C_SCAN;
               end else begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_NO_MEM;
                  rsp_owner_in  = owner_ff;
                  rsp_start_in  = '0;
                  rsp_size_in   = '0;
                  rsp_comp_in   = comp_ff;
                  state_in      = S_IDLE;
               end
            end
         end

         S_A_GRANT: begin
            left      = best_len_ff - size_ff;
            bstart_in = best_start_ff;
            if ((left == '0) || (left < min_rem_ff)) begin
               // Small leftover goes with the block: drop the free entry.
               bsize_in                 = best_len_ff;
               free_vld_in[best_idx_ff] = 1'b0;
            end else begin
               bsize_in   = size_ff;
               free_we    = 1'b1;
               free_waddr = best_idx_ff;
               free_wdata = '{start: best_start_ff + size_ff, length: left};
            end
            idx_in   = '0;
            state_in = S_A_AGE;
         end

         S_A_AGE: begin
            if (pend_ff && alloc_vld_ff[pa]) begin
               alloc_we        = 1'b1;
               alloc_waddr     = pa;
               alloc_wdata     = alloc_rdata;
               alloc_wdata.age = alloc_rdata.age + ADDR_W'(1);
            end
            if (scan_end) begin
               idx_in   = '0;
               state_in = S_A_PUT;
            end
         end

         S_A_PUT: begin
            alloc_we              = 1'b1;
            alloc_waddr           = slot_ff;
            alloc_wdata           = '{id: owner_ff, start: bstart_ff, length: bsize_ff, age: '0};
            alloc_vld_in[slot_ff] = 1'b1;
            rsp_valid_in          = 1'b1;
            rsp_status_in         = ST_OK;
            rsp_owner_in          = owner_ff;
            rsp_start_in          = bstart_ff;
            rsp_size_in           = bsize_ff;
            rsp_comp_in           = comp_ff;
            state_in              = S_IDLE;
         end

         S_C_SCAN: begin
            // Find the newest allocation not yet placed.
            if (pend_ff && alloc_vld_ff[pa] && !placed_ff[pa]) begin
               if (!sel_found_ff || (alloc_rdata.age < sel_ent_ff.age)) begin
                  sel_found_in = 1'b1;
                  sel_idx_in   = pa;
                  sel_ent_in   = alloc_rdata;
               end
            end
            if (scan_end) begin
               idx_in       = '0;
               sel_found_in = 1'b0;
               if (sel_found_ff) begin
                  alloc_we              = 1'b1;
                  alloc_waddr           = sel_idx_ff;
                  alloc_wdata           = sel_ent_ff;
                  alloc_wdata.start     = addr_ff[ADDR_W-1:0];
                  placed_in[sel_idx_ff] = 1'b1;
                  addr_in               = addr_ff + CAW'(sel_ent_ff.length);
               end else begin
                  // All packed: leave one free block above them if any space remains.
                  free_vld_in = '0;
                  if (mem_ext > addr_ff) begin
                     free_we        = 1'b1;
                     free_waddr     = '0;
                     free_wdata     = '{start: addr_ff[ADDR_W-1:0],
                                        length: rest[ADDR_W-1:0]};
                     free_vld_in[0] = 1'b1;
                  end
                  comp_in       = 1'b1;
                  best_found_in = 1'b0;
                  sum_in        = '0;
                  state_in      = S_A_SCAN;
               end
            end
         end

         S_R_FIND: begin
            if (pend_ff && alloc_vld_ff[pa] && !a_found_ff &&
                (alloc_rdata.id == owner_ff)) begin
               a_found_in = 1'b1;
               a_idx_in   = pa;
               a_ent_in   = alloc_rdata;
            end
            if (scan_end) begin
               idx_in = '0;
               if (a_found_ff) begin
                  lo_found_in = 1'b0;
                  hi_found_in = 1'b0;
                  state_in    = S_R_MERGE;
               end else begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_NOT_FOUND;
                  rsp_owner_in  = owner_ff;
                  rsp_start_in  = '0;
                  rsp_size_in   = '0;
                  rsp_comp_in   = 1'b0;
                  state_in      = S_IDLE;
               end
            end
         end

         S_R_MERGE: begin
            if (pend_ff && free_vld_ff[pf]) begin
               if (!lo_found_ff && (blk_end == {1'b0, a_ent_ff.start})) begin
                  lo_found_in = 1'b1;
                  lo_idx_in   = pf;
                  lo_start_in = free_rdata.start;
                  lo_len_in   = free_rdata.length;
               end else if (!hi_found_ff && ({1'b0, free_rdata.start} == rel_end)) begin
                  hi_found_in = 1'b1;
                  hi_idx_in   = pf;
                  hi_len_in   = free_rdata.length;
               end
            end
            if (scan_end) begin
               idx_in = '0;
               if (!lo_found_ff && !hi_found_ff && !fslot_found) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_REJECT;
                  rsp_owner_in  = owner_ff;
                  rsp_start_in  = '0;
                  rsp_size_in   = '0;
                  rsp_comp_in   = 1'b0;
                  state_in      = S_IDLE;
               end else begin
                  state_in = S_R_APPLY;
               end
            end
         end

         S_R_APPLY: begin
            free_we = 1'b1;
            if (lo_found_ff) begin
               free_waddr = lo_idx_ff;
               free_wdata = '{start: lo_start_ff,
                              length: lo_len_ff + a_ent_ff.length +
                                      (hi_found_ff ? hi_len_ff : '0)};
               if (hi_found_ff) begin
                  free_vld_in[hi_idx_ff] = 1'b0;
               end
            end else if (hi_found_ff) begin
               free_waddr = hi_idx_ff;
               free_wdata = '{start: a_ent_ff.start, length: hi_len_ff + a_ent_ff.length};
            end else begin
               free_waddr         = fslot;
               free_wdata         = '{start: a_ent_ff.start, length: a_ent_ff.length};
               free_vld_in[fslot] = 1'b1;
            end
            alloc_vld_in[a_idx_ff] = 1'b0;
            idx_in                 = '0;
            state_in               = S_R_AGE;
         end

         S_R_AGE: begin
            if (pend_ff && alloc_vld_ff[pa] && (alloc_rdata.age > a_ent_ff.age)) begin
               alloc_we        = 1'b1;
               alloc_waddr     = pa;
               alloc_wdata     = alloc_rdata;
               alloc_wdata.age = alloc_rdata.age - ADDR_W'(1);
            end
            if (scan_end) begin
               idx_in        = '0;
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_OK;
               rsp_owner_in  = owner_ff;
               rsp_start_in  = a_ent_ff.start;
               rsp_size_in   = a_ent_ff.length;
               rsp_comp_in   = 1'b0;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // The user makes register writes only while idle; not enforced. A size write rebuilds the tables.
      if (csr_we) begin
         case (csr_index)
            CSR_MEM_SIZE: begin
               mem_units_in = csr_wdata;
               state_in     = S_INIT;
            end
            CSR_POLICY:  policy_in  = csr_wdata[1:0];
            CSR_MIN_REM: min_rem_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         idx_ff       <= '0;
         pend_ff      <= 1'b0;
         mem_units_ff <= MEM_SIZE_RST;
         policy_ff    <= POL_FIRST;
         min_rem_ff   <= MIN_REM_RST;
         next_id_ff   <= FIRST_ID;
         free_vld_ff  <= '0;
         alloc_vld_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         pend_ff      <= pend_in;
         mem_units_ff <= mem_units_in;
         policy_ff    <= policy_in;
         min_rem_ff   <= min_rem_in;
         next_id_ff   <= next_id_in;
         free_vld_ff  <= free_vld_in;
         alloc_vld_ff <= alloc_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pidx_ff       <= pidx_in;
      placed_ff     <= placed_in;
      size_ff       <= size_in;
      owner_ff      <= owner_in;
      slot_ff       <= slot_in;
      comp_ff       <= comp_in;
      best_found_ff <= best_found_in;
      best_idx_ff   <= best_idx_in;
      best_start_ff <= best_start_in;
      best_len_ff   <= best_len_in;
      sum_ff        <= sum_in;
      sel_found_ff  <= sel_found_in;
      sel_idx_ff    <= sel_idx_in;
      sel_ent_ff    <= sel_ent_in;
      addr_ff       <= addr_in;
      a_found_ff    <= a_found_in;
      a_idx_ff      <= a_idx_in;
      a_ent_ff      <= a_ent_in;
      lo_found_ff   <= lo_found_in;
      lo_idx_ff     <= lo_idx_in;
      lo_start_ff   <= lo_start_in;
      lo_len_ff     <= lo_len_in;
      hi_found_ff   <= hi_found_in;
      hi_idx_ff     <= hi_idx_in;
      hi_len_ff     <= hi_len_in;
      bstart_ff     <= bstart_in;
      bsize_ff      <= bsize_in;
      rsp_status_ff <= rsp_status_in;
      rsp_owner_ff  <= rsp_owner_in;
      rsp_start_ff  <= rsp_start_in;
      rsp_size_ff   <= rsp_size_in;
      rsp_comp_ff   <= rsp_comp_in;
   end

   assign busy            = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_owner_pid   = rsp_owner_ff;
   assign rsp_block_start = rsp_start_ff;
   assign rsp_block_size  = rsp_size_ff;
   assign rsp_compacted   = rsp_comp_ff;

endmodule

/* verif/testbench.sv */
// Self-checking testbench for the variable partition allocator.
module testbench;
   import vpa_pkg::*;

   localparam int NFREE  = 16;
   localparam int NALLOC = 16;

   typedef struct {
      logic [1:0]  status;
      logic [15:0] owner;
      logic [15:0] bstart;
      logic [15:0] bsize;
      logic        compacted;
   } grant_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_op = OP_ALLOC;
   logic [15:0] req_request_size = '0;
   logic [15:0] req_release_pid = '0;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic [15:0] rsp_owner_pid;
   logic [15:0] rsp_block_start;
   logic [15:0] rsp_block_size;
   logic        rsp_compacted;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = CSR_MEM_SIZE;
   logic [15:0] csr_wdata = '0;

   // Shadow copy of the allocator: configuration and both tables.
   logic [15:0] total_units, min_rem;
   logic [1:0]  policy;
   logic [15:0] fr_start [NFREE];
   logic [15:0] fr_len   [NFREE];
   bit          fr_used  [NFREE];
   logic [15:0] al_id    [NALLOC];
   logic [15:0] al_start [NALLOC];
   logic [15:0] al_len   [NALLOC];
   logic [15:0] al_age   [NALLOC];
   bit          al_used  [NALLOC];
   logic [15:0] next_pid;

   grant_type pending_grants[$];
   int        failures = 0;
   int        idle_pct = 0;  // percent chance that the sender holds off after a beat, then per idle cycle

   variable_partition_allocator uut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #8000000;
      $display("Test completed with failures");
      $finish;
   end

   // ---------------------------------------------------------------- model
   function automatic void clear_free_table();
      for (int i = 0; i < NFREE; i++) begin
         fr_start[i] = '0;
         fr_len[i]   = '0;
         fr_used[i]  = 1'b0;
      end
   endfunction

   // Rebuild the layout after reset or a memory size write; ids survive.
   function automatic void rebuild_tables();
      clear_free_table();
      for (int i = 0; i < NALLOC; i++) begin
         al_used[i] = 1'b0;
         al_age[i]  = '0;
      end
      if (total_units != 0) begin
         fr_len[0]  = total_units;
         fr_used[0] = 1'b1;
      end
   endfunction

   function automatic int choose_block(logic [15:0] need);
      int  best = -1;
      bit  better;
      for (int i = 0; i < NFREE; i++) begin
         if (!fr_used[i] || fr_len[i] < need) continue;
         if (best < 0) begin
            best = i;
            continue;
         end
         if (policy == POL_BEST)
            better = fr_len[i] < fr_len[best] ||
                     (fr_len[i] == fr_len[best] && fr_start[i] < fr_start[best]);
         else if (policy == POL_WORST)
            better = fr_len[i] > fr_len[best] ||
                     (fr_len[i] == fr_len[best] && fr_start[i] < fr_start[best]);
         else
            better = fr_start[i] < fr_start[best];  // policy three also lands here
         if (better) best = i;
      end
      return best;
   endfunction

   // Pack live blocks from address zero, newest first.
   function automatic void pack_blocks();
      bit          placed [NALLOC];
      int unsigned addr = 0;
      int          pick;
      for (int i = 0; i < NALLOC; i++) placed[i] = 1'b0;
      for (int n = 0; n < NALLOC; n++) begin
         pick = -1;
         for (int i = 0; i < NALLOC; i++) begin
            if (!al_used[i] || placed[i]) continue;
            if (pick < 0 || al_age[i] < al_age[pick]) pick = i;
         end
         if (pick < 0) break;
         placed[pick]   = 1'b1;
         al_start[pick] = addr[15:0];
         addr += al_len[pick];
      end
      clear_free_table();
      if (int'(total_units) > addr) begin
         fr_start[0] = addr[15:0];
         fr_len[0]   = total_units - addr[15:0];
         fr_used[0]  = 1'b1;
      end
   endfunction

   function automatic int empty_free_slot();
      for (int i = 0; i < NFREE; i++)
         if (!fr_used[i]) return i;
      return -1;
   endfunction

   function automatic grant_type predict_grant(logic op, logic [15:0] size, logic [15:0] pid);
      grant_type   g = '{ST_OK, 16'd0, 16'd0, 16'd0, 1'b0};
      int          slot = -1, k, hit = -1, lo = -1, hi = -1, f;
      int unsigned total, s, len;
      logic [15:0] left, age;
      if (op == OP_ALLOC) begin
         g.owner  = next_pid;
         next_pid = next_pid + 16'd1;
         for (int i = 0; i < NALLOC; i++)
            if (!al_used[i]) begin
               slot = i;
               break;
            end
         if (size == 0 || slot < 0) begin
            g.status = ST_REJECT;
            return g;
         end
         k = choose_block(size);
         if (k < 0) begin
            total = 0;
            for (int i = 0; i < NFREE; i++)
               if (fr_used[i]) total += fr_len[i];
            if (total >= size) begin
               pack_blocks();
               g.compacted = 1'b1;
               k = choose_block(size);
            end
         end
         if (k < 0) begin
            g.status = ST_NO_MEM;
            return g;
         end
         left     = fr_len[k] - size;
         g.bstart = fr_start[k];
         if (left == 0 || left < min_rem) begin
            g.bsize     = fr_len[k];
            fr_used[k]  = 1'b0;
            fr_start[k] = '0;
            fr_len[k]   = '0;
         end else begin
            g.bsize     = size;
            fr_start[k] = fr_start[k] + size;
            fr_len[k]   = left;
         end
         for (int i = 0; i < NALLOC; i++)
            if (al_used[i]) al_age[i] = al_age[i] + 16'd1;
         al_used[slot]  = 1'b1;
         al_id[slot]    = g.owner;
         al_start[slot] = g.bstart;
         al_len[slot]   = g.bsize;
         al_age[slot]   = '0;
         return g;
      end
      g.owner = pid;
      for (int i = 0; i < NALLOC; i++)
         if (al_used[i] && al_id[i] == pid) begin
            hit = i;
            break;
         end
      if (hit < 0) begin
         g.status = ST_NOT_FOUND;
         return g;
      end
      s   = al_start[hit];
      len = al_len[hit];
      // Neighbors by address, with full-width sums so no wrap hides a miss.
      for (int i = 0; i < NFREE; i++) begin
         if (!fr_used[i]) continue;
         if (lo < 0 && int'(fr_start[i]) + int'(fr_len[i]) == s) lo = i;
         else if (hi < 0 && int'(fr_start[i]) == s + len) hi = i;
      end
      if (lo < 0 && hi < 0 && empty_free_slot() < 0) begin
         g.status = ST_REJECT;
         return g;
      end
      age      = al_age[hit];
      g.bstart = s[15:0];
      g.bsize  = len[15:0];
      if (lo >= 0) begin
         fr_len[lo] = fr_len[lo] + len[15:0];
         if (hi >= 0) begin
            fr_len[lo]   = fr_len[lo] + fr_len[hi];
            fr_used[hi]  = 1'b0;
            fr_start[hi] = '0;
            fr_len[hi]   = '0;
         end
      end else if (hi >= 0) begin
         fr_start[hi] = s[15:0];
         fr_len[hi]   = fr_len[hi] + len[15:0];
      end else begin
         f = empty_free_slot();
         fr_used[f]  = 1'b1;
         fr_start[f] = s[15:0];
         fr_len[f]   = len[15:0];
      end
      al_used[hit] = 1'b0;
      for (int i = 0; i < NALLOC; i++)
         if (al_used[i] && al_age[i] > age) al_age[i] = al_age[i] - 16'd1;
      return g;
   endfunction

   // ---------------------------------------------------------------- checker
   always @(posedge clock) begin
      grant_type want;
      if (!reset && rsp_valid) begin
         if (pending_grants.size() == 0) begin
            $error("result beat with nothing expected");
            failures++;
         end else begin
            want = pending_grants.pop_front();
            if (rsp_status !== want.status) begin
               $error("status expected %0d got %0d", want.status, rsp_status);
               failures++;
            end
            if (rsp_owner_pid !== want.owner) begin
               $error("owner_pid expected %0d got %0d", want.owner, rsp_owner_pid);
               failures++;
            end
            if (rsp_block_start !== want.bstart) begin
               $error("block_start expected %0d got %0d", want.bstart, rsp_block_start);
               failures++;
            end
            if (rsp_block_size !== want.bsize) begin
               $error("block_size expected %0d got %0d", want.bsize, rsp_block_size);
               failures++;
            end
            if (rsp_compacted !== want.compacted) begin
               $error("compacted expected %0d got %0d", want.compacted, rsp_compacted);
               failures++;
            end
         end
      end
   end

   // ---------------------------------------------------------------- drivers
   // Hold start high until the beat is taken; then drop it at random per idle_pct.
   task automatic send_beat(logic op, logic [15:0] size, logic [15:0] pid);
      start            <= 1'b1;
      req_op           <= op;
      req_request_size <= size;
      req_release_pid  <= pid;
      do @(posedge clock); while (busy);
      pending_grants.push_back(predict_grant(op, size, pid));
      if (idle_pct > 0 && $urandom_range(99, 0) < idle_pct) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(99, 0) < idle_pct);
      end
   endtask

   task automatic drain_results();
      start <= 1'b0;
      @(posedge clock);
      while (pending_grants.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Write a register only with nothing in flight.
   task automatic write_reg(logic [1:0] idx, logic [15:0] value);
      drain_results();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_MEM_SIZE: begin
            total_units = value;
            rebuild_tables();
         end
         CSR_POLICY:   policy = value[1:0];
         default:      min_rem = value;
      endcase
      @(posedge clock);
   endtask

   function automatic logic [15:0] live_pid();
      int idx[$];
      for (int i = 0; i < NALLOC; i++)
         if (al_used[i]) idx.push_back(i);
      if (idx.size() == 0) return 16'($urandom_range(65535, 0));
      return al_id[idx[$urandom_range(idx.size() - 1, 0)]];
   endfunction

   function automatic logic [15:0] rand16();
      return 16'($urandom_range(65535, 0));
   endfunction

   // ---------------------------------------------------------------- tests
   task automatic test_edges();
      send_beat(OP_ALLOC, 16'd0, 16'd0);            // zero size
      send_beat(OP_ALLOC, 16'hFFFF, 16'hFFFF);      // out of memory
      send_beat(OP_RELEASE, 16'd0, 16'd0);          // unknown id
      send_beat(OP_RELEASE, 16'hFFFF, 16'hFFFF);
      send_beat(OP_ALLOC, 16'd1, 16'd0);
      send_beat(OP_ALLOC, 16'd1023, 16'd0);         // exact fit of the remaining block
      send_beat(OP_RELEASE, 16'd0, live_pid());
      send_beat(OP_RELEASE, 16'd0, live_pid());
   endtask

   task automatic test_table_full();
      for (int i = 0; i < NALLOC + 1; i++) send_beat(OP_ALLOC, 16'd20, 16'd0);
      for (int i = 0; i < NALLOC; i++) send_beat(OP_RELEASE, 16'd0, live_pid());
   endtask

   task automatic test_compaction();
      logic [15:0] mid;
      write_reg(CSR_MEM_SIZE, 16'd100);
      write_reg(CSR_MIN_REM, 16'd0);
      send_beat(OP_ALLOC, 16'd30, 16'd0);
      send_beat(OP_ALLOC, 16'd30, 16'd0);
      mid = next_pid - 16'd1;
      send_beat(OP_ALLOC, 16'd30, 16'd0);
      send_beat(OP_RELEASE, 16'd0, mid);
      send_beat(OP_ALLOC, 16'd35, 16'd0);           // fits only after packing
      send_beat(OP_ALLOC, 16'd5, 16'd0);            // exact fit
      write_reg(CSR_MEM_SIZE, 16'd0);
      send_beat(OP_ALLOC, 16'd1, 16'd0);
      write_reg(CSR_MEM_SIZE, 16'hFFFF);
      write_reg(CSR_MIN_REM, 16'hFFFF);
      send_beat(OP_ALLOC, 16'h8000, 16'd0);         // whole memory absorbed
      send_beat(OP_RELEASE, 16'd0, live_pid());
   endtask

   task automatic test_random(int beats);
      int unsigned lim;
      for (int n = 0; n < beats; n++) begin
         if (n % 60 == 0) begin
            case ($urandom_range(7, 0))
               0:       write_reg(CSR_MEM_SIZE, 16'hFFFF);
               1:       write_reg(CSR_MEM_SIZE, 16'd1);
               default: write_reg(CSR_MEM_SIZE, 16'($urandom_range(400, 20)));
            endcase
            write_reg(CSR_POLICY, 16'($urandom_range(3, 0)));
            write_reg(CSR_MIN_REM, ($urandom_range(9, 0) == 0) ? 16'hFFFF
                                                               : 16'($urandom_range(20, 0)));
         end
         if (n == beats / 2) drain_results();       // let every result land once
         lim = (total_units < 8) ? 4 : total_units / 4;
         case ($urandom_range(19, 0))
            0:               send_beat(OP_ALLOC, rand16(), rand16());
            1:               send_beat(OP_RELEASE, rand16(), rand16());
            2,3,4,5,6,7,8,9: send_beat(OP_ALLOC, 16'($urandom_range(lim, 1)), rand16());
            default:         send_beat(OP_RELEASE, rand16(), live_pid());
         endcase
      end
   endtask

   initial begin
      total_units = MEM_SIZE_RST;
      min_rem     = MIN_REM_RST;
      policy      = POL_FIRST;
      next_pid    = FIRST_ID;
      rebuild_tables();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_edges();
      test_table_full();
      test_compaction();
      // Walk the sender through its idle phases.
      idle_pct = 0;
      test_random(300);
      idle_pct = 86;
      test_random(300);
      idle_pct = 14;
      test_random(300);
      idle_pct = 0;
      test_random(200);
      drain_results();
      repeat (20) @(posedge clock);
      if (failures == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end
endmodule

/* filelist.f */
design/vpa_pkg.sv
design/vpa_ram.sv
design/variable_partition_allocator.sv
verif/testbench.sv
